### rtl/circle_shape_collision_test_unit_assert.svh
// assertion macros for the collision test unit
`ifndef CIRCLE_SHAPE_COLLISION_TEST_UNIT_ASSERT_SVH
`define CIRCLE_SHAPE_COLLISION_TEST_UNIT_ASSERT_SVH

// checked only outside reset
`define CST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked in every cycle, reset included
`define CST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/cst_pkg.sv
package cst_pkg;

  localparam int MAG_W  = 33;
  localparam int CMP_W  = 34;
  localparam int SQ_W   = 68;
  localparam int LEN_W  = 34;
  localparam int REM_W  = 37;
  localparam int Q_W    = 15;
  localparam int SQRT_STAGES = LEN_W;
  localparam int DIV_STAGES  = Q_W;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = 2;

  localparam logic [1:0] ST_MISS = 2'd0;
  localparam logic [1:0] ST_HIT  = 2'd1;
  localparam logic [1:0] ST_COIN = 2'd2;

  localparam logic [15:0] NORM_MAX = 16'h7fff;
  localparam logic [15:0] NORM_NEG = 16'h8000;

  typedef enum logic [1:0] {
    K_MISS,
    K_COIN,
    K_ZERO,
    K_CALC
  } kind_t;

  // classified query handed from front to back
  typedef struct packed {
    kind_t              kind;
    logic               sgnx;
    logic               sgny;
    logic [MAG_W-1:0]   magx;
    logic [MAG_W-1:0]   magy;
    logic [SQ_W-1:0]    s;
    logic [31:0]        r;
    logic [30:0]        base;
  } item_t;

endpackage

### rtl/cst_front.sv
module cst_front
  import cst_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         op,
  input  logic [31:0]  self_x,
  input  logic [31:0]  self_y,
  input  logic [30:0]  self_radius,
  input  logic [30:0]  base_radius,
  input  logic [31:0]  other_x,
  input  logic [31:0]  other_y,
  input  logic [30:0]  other_radius,
  input  logic [30:0]  half_width,
  input  logic [30:0]  half_height,
  output logic         push,
  input  logic         push_ready,
  output item_t        push_item
);

  logic signed [32:0] ax, ay, hwp, hwn, hhp, hhn, cx, cy;
  logic [32:0]        magax, magay;
  logic signed [CMP_W-1:0] nx_c, ny_c;
  logic               inside_c;

  logic               v1, op1, inside1;
  logic signed [CMP_W-1:0] nx1, ny1;
  logic [31:0]        r1;
  logic [30:0]        base1;

  logic               v2, op2, inside2, sgnx2, sgny2;
  logic [MAG_W-1:0]   magx2, magy2, magx_c, magy_c;
  logic [65:0]        sqx2, sqy2;
  logic [63:0]        rr2;
  logic [31:0]        r2;
  logic [30:0]        base2;

  logic               rdy1, rdy2;
  logic [SQ_W-1:0]    s_c;
  logic [CMP_W-1:0]   nx1_neg, ny1_neg;

  always_comb begin
    ax  = $signed({self_x[31], self_x}) - $signed({other_x[31], other_x});
    ay  = $signed({self_y[31], self_y}) - $signed({other_y[31], other_y});
    hwp = $signed({2'b00, half_width});
    hhp = $signed({2'b00, half_height});
    hwn = -hwp;
    hhn = -hhp;
    cx  = (ax < hwn) ? hwn : ((ax > hwp) ? hwp : ax);
    cy  = (ay < hhn) ? hhn : ((ay > hhp) ? hhp : ay);
    inside_c = (cx == ax) && (cy == ay);
    magax = ax[32] ? 33'(-ax) : 33'(ax);
    magay = ay[32] ? 33'(-ay) : 33'(ay);
    if (!op) begin
      nx_c = $signed({ax[32], ax});
      ny_c = $signed({ay[32], ay});
    end else if (inside_c) begin
      // push out along the axis of the larger offset, ties go to the y face
      if (magax > magay) begin
        nx_c = $signed({(ax > 0) ? hwp[32] : hwn[32], (ax > 0) ? hwp : hwn})
               - $signed({ax[32], ax});
        ny_c = '0;
      end else begin
        nx_c = '0;
        ny_c = $signed({(ay > 0) ? hhp[32] : hhn[32], (ay > 0) ? hhp : hhn})
               - $signed({ay[32], ay});
      end
    end else begin
      nx_c = $signed({ax[32], ax}) - $signed({cx[32], cx});
      ny_c = $signed({ay[32], ay}) - $signed({cy[32], cy});
    end
  end

  assign rdy2     = !v2 || push_ready;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
    if (rdy1) begin
      op1     <= op;
      inside1 <= inside_c;
      nx1     <= nx_c;
      ny1     <= ny_c;
      r1      <= op ? {1'b0, self_radius} : ({1'b0, self_radius} + {1'b0, other_radius});
      base1   <= base_radius;
    end
  end

  always_comb begin
    nx1_neg = CMP_W'(-nx1);
    ny1_neg = CMP_W'(-ny1);
    magx_c  = nx1[CMP_W-1] ? nx1_neg[MAG_W-1:0] : nx1[MAG_W-1:0];
    magy_c  = ny1[CMP_W-1] ? ny1_neg[MAG_W-1:0] : ny1[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2) begin
      op2     <= op1;
      inside2 <= inside1;
      sgnx2   <= nx1[CMP_W-1];
      sgny2   <= ny1[CMP_W-1];
      magx2   <= magx_c;
      magy2   <= magy_c;
      sqx2    <= magx_c * magx_c;
      sqy2    <= magy_c * magy_c;
      rr2     <= r1 * r1;
      r2      <= r1;
      base2   <= base1;
    end
  end

  always_comb begin
    s_c = {2'b00, sqx2} + {2'b00, sqy2};
    push_item.sgnx = sgnx2;
    push_item.sgny = sgny2;
    push_item.magx = magx2;
    push_item.magy = magy2;
    push_item.s    = s_c;
    push_item.r    = r2;
    push_item.base = base2;
    if ((!op2 || !inside2) && (s_c > {4'b0000, rr2})) begin
      push_item.kind = K_MISS;
    end else if (s_c == '0) begin
      push_item.kind = op2 ? K_ZERO : K_COIN;
    end else begin
      push_item.kind = K_CALC;
    end
  end

  assign push = v2 && push_ready;

endmodule

### rtl/cst_fifo.sv
module cst_fifo
  import cst_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  output logic   push_ready,
  input  item_t  push_item,
  input  logic   pop,
  output logic   pop_valid,
  output item_t  pop_item
);

  item_t                 mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]    wptr, rptr;
  logic [FIFO_AW:0]      count;

  assign push_ready = (count != FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

endmodule

### rtl/cst_back.sv
module cst_back
  import cst_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         pop_valid,
  input  item_t        pop_item,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [1:0]   status,
  output logic [15:0]  normal_x,
  output logic [15:0]  normal_y,
  output logic [31:0]  depth
);

  localparam int PREP  = SQRT_STAGES;
  localparam int NST   = SQRT_STAGES + 1 + DIV_STAGES;

  typedef struct packed {
    item_t              it;
    logic [SQ_W-1:0]    s_sh;
    logic [LEN_W-1:0]   root;
    logic [REM_W-1:0]   rem;
    logic [LEN_W-1:0]   remx;
    logic [LEN_W-1:0]   remy;
    logic [Q_W-1:0]     qx;
    logic [Q_W-1:0]     qy;
    logic               satx;
    logic               saty;
    logic [31:0]        dep;
  } stage_t;

  stage_t  p [NST+1];
  logic    v [NST+1];
  logic    en;

  assign en  = !out_valid || out_ready;
  assign pop = en && pop_valid;

  always_comb begin
    p[0]      = '0;
    p[0].it   = pop_item;
    p[0].s_sh = pop_item.s;
    v[0]      = pop_valid;
  end

  for (genvar g = 0; g < NST; g++) begin : g_stage
    stage_t nxt;

    if (g < PREP) begin : g_sqrt
      logic [REM_W-1:0] rem_sh, trial;
      always_comb begin
        nxt    = p[g];
        rem_sh = {p[g].rem[REM_W-3:0], p[g].s_sh[SQ_W-1 -: 2]};
        trial  = {1'b0, p[g].root, 2'b01};
        nxt.s_sh = {p[g].s_sh[SQ_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          nxt.rem  = rem_sh - trial;
          nxt.root = {p[g].root[LEN_W-2:0], 1'b1};
        end else begin
          nxt.rem  = rem_sh;
          nxt.root = {p[g].root[LEN_W-2:0], 1'b0};
        end
      end
    end else if (g == PREP) begin : g_prep
      logic signed [35:0] d;
      always_comb begin
        nxt      = p[g];
        // a component at least as long as the length saturates the normal
        nxt.satx = ({1'b0, p[g].it.magx} >= p[g].root);
        nxt.saty = ({1'b0, p[g].it.magy} >= p[g].root);
        nxt.remx = nxt.satx ? '0 : {1'b0, p[g].it.magx};
        nxt.remy = nxt.saty ? '0 : {1'b0, p[g].it.magy};
        d = $signed({4'b0000, p[g].it.r}) - $signed({2'b00, p[g].root});
        if (d > 36'sh07fffffff) begin
          nxt.dep = 32'h7fffffff;
        end else if (d < -36'sh080000000) begin
          nxt.dep = 32'h80000000;
        end else begin
          nxt.dep = d[31:0];
        end
      end
    end else begin : g_div
      logic [LEN_W:0] rx, ry;
      logic           gex, gey;
      always_comb begin
        nxt = p[g];
        rx  = {p[g].remx, 1'b0};
        ry  = {p[g].remy, 1'b0};
        gex = (rx >= {1'b0, p[g].root});
        gey = (ry >= {1'b0, p[g].root});
        nxt.remx = gex ? LEN_W'(rx - {1'b0, p[g].root}) : rx[LEN_W-1:0];
        nxt.remy = gey ? LEN_W'(ry - {1'b0, p[g].root}) : ry[LEN_W-1:0];
        nxt.qx   = {p[g].qx[Q_W-2:0], gex};
        nxt.qy   = {p[g].qy[Q_W-2:0], gey};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[g+1] <= 1'b0;
      end else if (en) begin
        v[g+1] <= v[g];
      end
      if (en) begin
        p[g+1] <= nxt;
      end
    end
  end

  function automatic logic [15:0] norm_comp(logic sgn, logic sat, logic [Q_W-1:0] q);
    logic [15:0] qq;
    qq = {1'b0, q};
    if (sat) begin
      return sgn ? NORM_NEG : NORM_MAX;
    end
    return sgn ? 16'(-qq) : qq;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v[NST];
    end
    if (en) begin
      case (p[NST].it.kind)
        K_MISS: begin
          status   <= ST_MISS;
          normal_x <= '0;
          normal_y <= NORM_MAX;
          depth    <= {1'b0, p[NST].it.base};
        end
        K_COIN: begin
          status   <= ST_COIN;
          normal_x <= '0;
          normal_y <= '0;
          depth    <= '0;
        end
        K_ZERO: begin
          status   <= ST_HIT;
          normal_x <= '0;
          normal_y <= '0;
          depth    <= p[NST].it.r;
        end
        default: begin
          status   <= ST_HIT;
          normal_x <= norm_comp(p[NST].it.sgnx, p[NST].satx, p[NST].qx);
          normal_y <= norm_comp(p[NST].it.sgny, p[NST].saty, p[NST].qy);
          depth    <= p[NST].dep;
        end
      endcase
    end
  end

endmodule

### rtl/circle_shape_collision_test_unit.sv
// 2 front stages, the queue, 34 square root stages, 1 prep, 15 divide, 1 output
// throughput: one query per cycle while the output and the queue do not stall; the
// bit-per-stage square root and divider pipelines take a new query every cycle and a
// 4 entry queue splits front and back
// reset: synchronous, active high; clears valid bits, queue pointers and queue count only
module circle_shape_collision_test_unit
  import cst_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // self_x, self_y, self_radius, base_radius, other_x, other_y, other_radius,
  // half_width, half_height, zero fill
  input  logic [287:0]  s_axis_tdata,
  // operation
  input  logic          s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // normal_x, normal_y, depth
  output logic [63:0]   m_axis_tdata,
  // status
  output logic [1:0]    m_axis_tuser
);

  logic   push, push_ready, pop, pop_valid;
  item_t  push_item, pop_item;

  cst_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .op           (s_axis_tuser),
    .self_x       (s_axis_tdata[31:0]),
    .self_y       (s_axis_tdata[63:32]),
    .self_radius  (s_axis_tdata[94:64]),
    .base_radius  (s_axis_tdata[125:95]),
    .other_x      (s_axis_tdata[157:126]),
    .other_y      (s_axis_tdata[189:158]),
    .other_radius (s_axis_tdata[220:190]),
    .half_width   (s_axis_tdata[251:221]),
    .half_height  (s_axis_tdata[282:252]),
    .push         (push),
    .push_ready   (push_ready),
    .push_item    (push_item)
  );

  cst_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item)
  );

  cst_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (m_axis_tuser),
    .normal_x  (m_axis_tdata[15:0]),
    .normal_y  (m_axis_tdata[31:16]),
    .depth     (m_axis_tdata[63:32])
  );

endmodule

### rtl/cst_checker.sv
`include "circle_shape_collision_test_unit_assert.svh"

module cst_checker
  import cst_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  input  logic          s_axis_tready,
  input  logic [287:0]  s_axis_tdata,
  input  logic          s_axis_tuser,
  input  logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  input  logic [63:0]   m_axis_tdata,
  input  logic [1:0]    m_axis_tuser
);

  logic         in_wait;
  logic [288:0] in_word;
  logic         out_miss, out_coin;
  assign in_wait  = s_axis_tvalid && !s_axis_tready;
  assign in_word  = {s_axis_tuser, s_axis_tdata};
  assign out_miss = m_axis_tvalid && (m_axis_tuser == ST_MISS);
  assign out_coin = m_axis_tvalid && (m_axis_tuser == ST_COIN);

  `CST_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")
  `CST_ASSERT(a_in_hold, in_wait |=> s_axis_tvalid && $stable(in_word), "input beat changed")
  `CST_ASSERT(a_miss, out_miss |-> m_axis_tdata[31:0] == {NORM_MAX, 16'h0000}, "miss normal wrong")
  `CST_ASSERT(a_coin, out_coin |-> m_axis_tdata == 64'h0, "coincident data not zero")
  `CST_ASSERT_ALWAYS(a_rst, rst |=> !m_axis_tvalid, "valid out of reset")

endmodule

bind circle_shape_collision_test_unit cst_checker u_cst_checker (.*);

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import cst_pkg::*;

  typedef struct {
    logic        op;
    logic [31:0] sx, sy;
    logic [30:0] rad, base;
    logic [31:0] ox, oy;
    logic [30:0] orad, hw, hh;
  } query_t;

  typedef struct {
    logic [1:0]  st;
    logic [15:0] nx, ny;
    logic [31:0] dp;
  } contact_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [287:0] s_axis_tdata = '0;
  logic s_axis_tuser = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [63:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  circle_shape_collision_test_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always #5 clk = ~clk;

  query_t   pending_q[$];
  contact_t contact_q[$];
  int       errors = 0;
  int       n_sent = 0, n_got = 0, n_hit = 0, n_miss = 0, n_coin = 0;
  int       send_idle = 0, recv_idle = 0;
  longint   cycles = 0;
  bit       started = 0;
  bit       held = 0;

  function automatic logic [67:0] isqrt(logic [67:0] s);
    logic [67:0] res, c;
    res = 0;
    for (int b = 34; b >= 0; b--) begin
      c = res | (68'd1 << b);
      if ({4'd0, c} * {4'd0, c} <= {4'd0, s}) res = c;
    end
    return res;
  endfunction

  function automatic logic [15:0] unit_comp(longint c, logic [67:0] len);
    logic [67:0] mag, q;
    mag = (c < 0) ? -c : c;
    q = (mag << 15) / len;
    if (c < 0) return (q > 32768) ? NORM_NEG : 16'(-q);
    return (q > 32767) ? NORM_MAX : q[15:0];
  endfunction

  function automatic logic [31:0] sat_depth(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic contact_t collide(query_t q);
    contact_t r;
    longint ax, ay, hw, hh, cx, cy, nx, ny, rs, mx, my;
    logic [67:0] s, len;
    bit in_box;
    ax = longint'($signed(q.sx)) - longint'($signed(q.ox));
    ay = longint'($signed(q.sy)) - longint'($signed(q.oy));
    r.st = ST_MISS; r.nx = 16'd0; r.ny = NORM_MAX; r.dp = {1'b0, q.base};
    if (!q.op) begin
      rs = longint'(q.rad) + longint'(q.orad);
      // squares can exceed 2^63, so keep them unsigned
      s = {4'd0, ax * ax} + {4'd0, ay * ay};
      if (s > 68'(rs) * 68'(rs)) return r;
      if (s == 0) begin
        r.st = ST_COIN; r.nx = 0; r.ny = 0; r.dp = 0;
        return r;
      end
      len = isqrt(s);
      r.st = ST_HIT; r.nx = unit_comp(ax, len); r.ny = unit_comp(ay, len);
      r.dp = sat_depth(rs - longint'(len));
      return r;
    end
    hw = q.hw; hh = q.hh;
    cx = ax < -hw ? -hw : (ax > hw ? hw : ax);
    cy = ay < -hh ? -hh : (ay > hh ? hh : ay);
    in_box = (cx == ax) && (cy == ay);
    if (in_box) begin
      mx = ax < 0 ? -ax : ax;
      my = ay < 0 ? -ay : ay;
      if (mx > my) cx = ax > 0 ? hw : -hw;
      else cy = ay > 0 ? hh : -hh;
      nx = cx - ax; ny = cy - ay;
    end else begin
      nx = ax - cx; ny = ay - cy;
    end
    s = {4'd0, nx * nx} + {4'd0, ny * ny};
    if (!in_box && s > 68'(q.rad) * 68'(q.rad)) return r;
    r.st = ST_HIT;
    if (s == 0) begin
      r.nx = 0; r.ny = 0; r.dp = {1'b0, q.rad};
      return r;
    end
    len = isqrt(s);
    r.nx = unit_comp(nx, len); r.ny = unit_comp(ny, len);
    r.dp = sat_depth(longint'(q.rad) - longint'(len));
    return r;
  endfunction

  // driver: a waiting beat is held until accepted
  always @(negedge clk) begin
    if (!rst && started) begin
      if (!(s_axis_tvalid && held)) begin
        if (pending_q.size() > 0 && !($urandom_range(99) < send_idle)) begin
          s_axis_tvalid <= 1;
          s_axis_tuser  <= pending_q[0].op;
          s_axis_tdata  <= {4'd0, pending_q[0].hh, pending_q[0].hw, pending_q[0].orad,
                            pending_q[0].oy, pending_q[0].ox, pending_q[0].base,
                            pending_q[0].rad, pending_q[0].sy, pending_q[0].sx};
        end else begin
          s_axis_tvalid <= 0;
        end
      end
      m_axis_tready <= !($urandom_range(99) < recv_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    held = s_axis_tvalid && !s_axis_tready;
    if (!rst && started && s_axis_tvalid && s_axis_tready) begin
      contact_q.push_back(collide(pending_q.pop_front()));
      n_sent++;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_got++;
      if (contact_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        contact_t e;
        e = contact_q.pop_front();
        case (e.st)
          ST_HIT:  n_hit++;
          ST_MISS: n_miss++;
          default: n_coin++;
        endcase
        if (m_axis_tuser !== e.st) begin
          $error("status exp %0d got %0d", e.st, m_axis_tuser); errors++;
        end
        if (m_axis_tdata[15:0] !== e.nx) begin
          $error("normal_x exp %h got %h", e.nx, m_axis_tdata[15:0]); errors++;
        end
        if (m_axis_tdata[31:16] !== e.ny) begin
          $error("normal_y exp %h got %h", e.ny, m_axis_tdata[31:16]); errors++;
        end
        if (m_axis_tdata[63:32] !== e.dp) begin
          $error("depth exp %h got %h", e.dp, m_axis_tdata[63:32]); errors++;
        end
      end
    end
    if (cycles > 400000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] rcoord(int sc);
    case (sc)
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000)) - 1000) <<< 12;
      default: return 32'($signed($urandom_range(200000)) - 100000);
    endcase
  endfunction

  function automatic logic [30:0] rlen(int sc);
    case (sc)
      0: return 31'($urandom);
      1: return 31'($urandom_range(1500)) << 12;
      default: return 31'($urandom_range(120000));
    endcase
  endfunction

  function automatic query_t rand_query();
    query_t q;
    int sc;
    sc = $urandom_range(9) == 0 ? 0 : ($urandom_range(1) ? 1 : 2);
    q.op = $urandom_range(1);
    q.ox = rcoord(sc); q.oy = rcoord(sc);
    q.sx = q.ox + rcoord(sc); q.sy = q.oy + rcoord(sc);
    if (sc == 0) begin
      q.sx = rcoord(0); q.sy = rcoord(0);
    end
    q.rad = rlen(sc); q.base = 31'($urandom); q.orad = rlen(sc);
    q.hw = rlen(sc); q.hh = rlen(sc);
    if ($urandom_range(15) == 0) begin
      q.sx = q.ox; q.sy = q.oy;
    end
    if ($urandom_range(15) == 0) q.sx = q.ox + q.hw;
    return q;
  endfunction

  function automatic query_t mk(logic op, logic [31:0] sx, sy, logic [30:0] rad,
                                logic [31:0] ox, oy, logic [30:0] orad, hw, hh);
    query_t q;
    q.op = op; q.sx = sx; q.sy = sy; q.rad = rad; q.base = 31'h1234;
    q.ox = ox; q.oy = oy; q.orad = orad; q.hw = hw; q.hh = hh;
    return q;
  endfunction

  task automatic wait_drained();
    while (pending_q.size() > 0 || contact_q.size() > 0 || s_axis_tvalid)
      @(posedge clk);
  endtask

  initial begin
    localparam logic [31:0] ONE = 32'h10000;
    localparam logic [30:0] RMAX = 31'h7fffffff;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;
    started = 1;
    // directed corners
    pending_q.push_back(mk(0, 0, 0, ONE, 0, 0, ONE, 0, 0));
    pending_q.push_back(mk(0, ONE, 0, ONE, 0, 0, ONE, 0, 0));
    pending_q.push_back(mk(0, 5 * ONE, 0, ONE, 0, 0, ONE, 0, 0));
    pending_q.push_back(mk(0, 2 * ONE, 0, ONE, 0, 0, ONE, 0, 0));
    pending_q.push_back(mk(0, 32'h7fffffff, 32'h7fffffff, RMAX, 32'h80000000,
                           32'h80000000, RMAX, 0, 0));
    pending_q.push_back(mk(0, 32'h80000000, 0, RMAX, 32'h7fffffff, 0, RMAX, 0, 0));
    pending_q.push_back(mk(0, 0, 1, 0, 0, 0, 1, 0, 0));
    pending_q.push_back(mk(0, -ONE, -ONE, ONE, 0, 0, ONE, 0, 0));
    pending_q.push_back(mk(1, 0, 0, ONE, 0, 0, 0, ONE, ONE));
    pending_q.push_back(mk(1, ONE / 2, 0, ONE, 0, 0, 0, ONE, ONE));
    pending_q.push_back(mk(1, 0, -ONE / 2, ONE, 0, 0, 0, ONE, ONE));
    pending_q.push_back(mk(1, ONE / 2, ONE / 2, ONE, 0, 0, 0, ONE, ONE));
    pending_q.push_back(mk(1, ONE, 0, ONE, 0, 0, 0, ONE, ONE));
    pending_q.push_back(mk(1, 0, 0, ONE, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(1, 3 * ONE / 2, 0, ONE, 0, 0, 0, ONE, ONE));
    pending_q.push_back(mk(1, 5 * ONE, 0, ONE, 0, 0, 0, ONE, ONE));
    pending_q.push_back(mk(1, 2 * ONE, 2 * ONE, ONE, 0, 0, 0, ONE, ONE));
    pending_q.push_back(mk(1, 32'h7fffffff, 32'h80000000, RMAX, 32'h80000000,
                           32'h7fffffff, 0, RMAX, RMAX));
    pending_q.push_back(mk(1, 0, 0, RMAX, 0, 0, RMAX, RMAX, RMAX));
    pending_q.push_back(mk(1, -ONE / 4, ONE / 2, 0, 0, 0, 0, ONE, ONE));
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = ph == 0 ? 21 : (ph == 1 ? 49 : 0);
      recv_idle = ph == 0 ? 49 : (ph == 1 ? 21 : 0);
      for (int i = 0; i < 630; i++) pending_q.push_back(rand_query());
      wait_drained();
    end
    repeat (70) @(posedge clk);
    $display("sent %0d queries, got %0d results: %0d hit, %0d miss, %0d coincident",
             n_sent, n_got, n_hit, n_miss, n_coin);
    if (errors == 0 && contact_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
